>>> src/hfq_pkg.sv
// ----------------------------------------------------------------------------
// hfq_pkg
// shared types and widths for the terrain height query block
// ----------------------------------------------------------------------------
`default_nettype none

package hfq_pkg;

  localparam int GRID_SIDE = 128;
  localparam int CW        = $clog2(GRID_SIDE);
  localparam int AW        = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int IDX_W     = 7;
  localparam int COORD_W   = 32;
  localparam int CNT_W     = 8;
  localparam int SIZE_W    = 31;

  // plane arithmetic widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NRM_W  = PROD_W + 1;
  localparam int NUM_W  = NRM_W + DIFF_W + 1;
  localparam int QB     = 41;

  localparam int CELL_LAT  = CW + 2;
  localparam int PLANE_LAT = 5;
  localparam int DIV_LAT   = QB + 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  localparam int VTX_W = $bits(vertex_t);

endpackage

`default_nettype wire

>>> src/hfq_req_if.sv
// ----------------------------------------------------------------------------
// hfq_req_if
// request channel: vertex write or height query
// ----------------------------------------------------------------------------
`default_nettype none

interface hfq_req_if;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [6:0]          grid_col;
  logic [6:0]          grid_row;
  logic signed [31:0]  vert_x;
  logic signed [31:0]  vert_y;
  logic signed [31:0]  vert_z;
  logic signed [31:0]  query_x;
  logic signed [31:0]  query_z;

  modport source (output valid, mode, grid_col, grid_row, vert_x, vert_y, vert_z,
                  query_x, query_z, input ready);
  modport sink   (input valid, mode, grid_col, grid_row, vert_x, vert_y, vert_z,
                  query_x, query_z, output ready);
endinterface

`default_nettype wire

>>> src/hfq_rsp_if.sv
// ----------------------------------------------------------------------------
// hfq_rsp_if
// result channel: plane height and degenerate flag
// ----------------------------------------------------------------------------
`default_nettype none

interface hfq_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  height;
  logic                degenerate;

  modport source (output valid, height, degenerate, input ready);
  modport sink   (input valid, height, degenerate, output ready);
endinterface

`default_nettype wire

>>> src/hfq_ram.sv
// ----------------------------------------------------------------------------
// hfq_ram
// one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module hfq_ram #(
  parameter int W     = 96,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [W-1:0]             rdata0,
  output logic      [W-1:0]             rdata1
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

>>> src/hfq_cell.sv
// ----------------------------------------------------------------------------
// hfq_cell
// maps one coordinate to a clamped grid cell and exact remainder
// ----------------------------------------------------------------------------
`default_nettype none

module hfq_cell (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [hfq_pkg::COORD_W-1:0] coord,
  input  wire logic [hfq_pkg::SIZE_W-1:0]  size,
  input  wire logic [hfq_pkg::CW-1:0]      nm1,
  input  wire logic [hfq_pkg::CW-1:0]      nm2,
  output logic      [hfq_pkg::CW-1:0]      cell_idx,
  output logic      [31:0]                 rem
);
  import hfq_pkg::*;

  localparam int T_W  = COORD_W + 2;
  localparam int CN_W = T_W + CW + 1;
  localparam int RW   = 32 + CW;

  logic signed [T_W-1:0]  t;
  logic signed [CN_W-1:0] num;
  logic signed [CN_W-1:0] num_r;
  logic [RW-1:0]          limit_r;
  logic [31:0]            d_r;
  logic [CW-1:0]          nm2_r;

  logic [RW-1:0] drem [CW+1];
  logic [CW-1:0] dq   [CW+1];
  logic          dlo  [CW+1];
  logic          dhi  [CW+1];
  logic [31:0]   dd   [CW+1];
  logic [CW-1:0] dn   [CW+1];

  assign t   = $signed({coord[COORD_W-1], coord, 1'b0}) + $signed({3'b000, size});
  assign num = CN_W'(t * $signed({1'b0, nm1}));

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= num;
      limit_r <= RW'(nm2 * {size, 1'b0});
      d_r     <= {size, 1'b0};
      nm2_r   <= nm2;
    end
  end

  // classify: below the grid, at or past the last cell, or inside
  always_ff @(posedge clk) begin
    if (en) begin
      dlo[0]  <= num_r[CN_W-1];
      dhi[0]  <= !num_r[CN_W-1] && ($unsigned(num_r) >= CN_W'(limit_r));
      drem[0] <= num_r[RW-1:0];
      dq[0]   <= '0;
      dd[0]   <= d_r;
      dn[0]   <= nm2_r;
    end
  end

  for (genvar j = 0; j < CW; j++) begin : g_div
    localparam int K = CW - 1 - j;
    logic [RW-1:0] trial;
    assign trial = {{CW{1'b0}}, dd[j]} << K;
    always_ff @(posedge clk) begin
      if (en) begin
        dlo[j+1] <= dlo[j];
        dhi[j+1] <= dhi[j];
        dd[j+1]  <= dd[j];
        dn[j+1]  <= dn[j];
        if (drem[j] >= trial) begin
          drem[j+1] <= drem[j] - trial;
          dq[j+1]   <= dq[j] | CW'(1 << K);
        end else begin
          drem[j+1] <= drem[j];
          dq[j+1]   <= dq[j];
        end
      end
    end
  end

  always_comb begin
    if (dlo[CW]) begin
      cell_idx = '0;
      rem      = '0;
    end else if (dhi[CW]) begin
      cell_idx = dn[CW];
      rem      = '0;
    end else begin
      cell_idx = dq[CW];
      rem      = drem[CW][31:0];
    end
  end

endmodule

`default_nettype wire

>>> src/hfq_plane.sv
// ----------------------------------------------------------------------------
// hfq_plane
// triangle normal and plane numerator, five registered stages
// ----------------------------------------------------------------------------
`default_nettype none

module hfq_plane (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire hfq_pkg::vertex_t                    va,
  input  wire hfq_pkg::vertex_t                    vb,
  input  wire hfq_pkg::vertex_t                    vc,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]  qx,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]  qz,
  output logic signed [hfq_pkg::NUM_W-1:0]         num,
  output logic signed [hfq_pkg::NRM_W-1:0]         ny,
  output logic signed [hfq_pkg::COORD_W-1:0]       ay
);
  import hfq_pkg::*;

  localparam int LO_W = 34;
  localparam int HI_W = NRM_W - LO_W;

  logic signed [DIFF_W-1:0] s1x, s1y, s1z, s2x, s2y, s2z, dx1, dz1;
  logic signed [COORD_W-1:0] ay1, ay2, ay3, ay4;
  logic signed [PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [DIFF_W-1:0] dx2, dz2, dx3, dz3;
  logic signed [NRM_W-1:0]  nx3, ny3, nz3, ny4;
  logic signed [LO_W+DIFF_W:0]  pxl, pzl;
  logic signed [HI_W+DIFF_W-1:0] pxh, pzh;

  function automatic logic signed [DIFF_W-1:0] dif(input logic signed [COORD_W-1:0] p,
                                                    input logic signed [COORD_W-1:0] q);
    dif = DIFF_W'(p) - DIFF_W'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      // edge vectors
      s1x <= dif(vb.x, va.x);
      s1y <= dif(vb.y, va.y);
      s1z <= dif(vb.z, va.z);
      s2x <= dif(vc.x, va.x);
      s2y <= dif(vc.y, va.y);
      s2z <= dif(vc.z, va.z);
      dx1 <= dif(va.x, qx);
      dz1 <= dif(va.z, qz);
      ay1 <= va.y;
      // cross product terms
      p_yz <= s1y * s2z;
      p_zy <= s1z * s2y;
      p_zx <= s1z * s2x;
      p_xz <= s1x * s2z;
      p_xy <= s1x * s2y;
      p_yx <= s1y * s2x;
      dx2  <= dx1;
      dz2  <= dz1;
      ay2  <= ay1;
      // normal
      nx3 <= NRM_W'(p_yz) - NRM_W'(p_zy);
      ny3 <= NRM_W'(p_zx) - NRM_W'(p_xz);
      nz3 <= NRM_W'(p_xy) - NRM_W'(p_yx);
      dx3 <= dx2;
      dz3 <= dz2;
      ay3 <= ay2;
      // split products
      pxl <= $signed({1'b0, nx3[LO_W-1:0]}) * dx3;
      pxh <= $signed(nx3[NRM_W-1:LO_W]) * dx3;
      pzl <= $signed({1'b0, nz3[LO_W-1:0]}) * dz3;
      pzh <= $signed(nz3[NRM_W-1:LO_W]) * dz3;
      ny4 <= ny3;
      ay4 <= ay3;
      // numerator
      num <= (NUM_W'(pxh) <<< LO_W) + NUM_W'(pxl) + (NUM_W'(pzh) <<< LO_W) + NUM_W'(pzl);
      ny  <= ny4;
      ay  <= ay4;
    end
  end

endmodule

`default_nettype wire

>>> src/hfq_div.sv
// ----------------------------------------------------------------------------
// hfq_div
// pipelined restoring divide of the plane numerator, floor and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module hfq_div (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [hfq_pkg::NUM_W-1:0]    num,
  input  wire logic signed [hfq_pkg::NRM_W-1:0]    ny,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]  ay,
  output logic signed [hfq_pkg::COORD_W-1:0]       height,
  output logic                                     degenerate
);
  import hfq_pkg::*;

  localparam int TW = NRM_W + QB;

  typedef struct packed {
    logic                      neg;
    logic                      nyz;
    logic                      numz;
    logic                      numneg;
    logic                      ovf;
    logic signed [COORD_W-1:0] ay;
  } side_t;

  logic [NUM_W-1:0] nm0;
  logic [NRM_W-1:0] dm0;
  side_t            sd0;
  side_t            sd  [QB+1];
  logic [NUM_W-1:0] rm  [QB+1];
  logic [QB-1:0]    qt  [QB+1];
  logic [NRM_W-1:0] dm  [QB+1];

  logic [QB:0]      qm;
  logic             clamp;
  logic [QB-1:0]    qc;
  logic signed [QB+1:0] qs;
  logic signed [QB+2:0] hs;

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      nm0        <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dm0        <= ny[NRM_W-1] ? NRM_W'(-ny) : NRM_W'(ny);
      sd0.neg    <= num[NUM_W-1] ^ ny[NRM_W-1];
      sd0.nyz    <= (ny == '0);
      sd0.numz   <= (num == '0);
      sd0.numneg <= num[NUM_W-1];
      sd0.ovf    <= 1'b0;
      sd0.ay     <= ay;
    end
  end

  // quotient too large for the bit range
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= '{neg: sd0.neg, nyz: sd0.nyz, numz: sd0.numz, numneg: sd0.numneg,
                 ovf: (TW'(nm0) >= {dm0, {QB{1'b0}}}), ay: sd0.ay};
      rm[0] <= nm0;
      qt[0] <= '0;
      dm[0] <= dm0;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int K = QB - 1 - j;
    logic [TW-1:0] trial;
    assign trial = TW'(dm[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1] <= sd[j];
        dm[j+1] <= dm[j];
        if (TW'(rm[j]) >= trial) begin
          rm[j+1] <= rm[j] - trial[NUM_W-1:0];
          qt[j+1] <= qt[j] | (QB'(1) << K);
        end else begin
          rm[j+1] <= rm[j];
          qt[j+1] <= qt[j];
        end
      end
    end
  end

  always_comb begin
    qm    = {1'b0, qt[QB]} + (QB+1)'(sd[QB].neg && (rm[QB] != '0));
    clamp = sd[QB].ovf || (qm > ((QB+1)'(1) << (QB - 1)));
    qc    = clamp ? (QB'(1) << (QB - 1)) : qm[QB-1:0];
    qs    = sd[QB].neg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    hs    = (QB+3)'(sd[QB].ay) + (QB+3)'(qs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= sd[QB].nyz;
      if (sd[QB].nyz) begin
        if (sd[QB].numz) begin
          height <= '0;
        end else if (sd[QB].numneg) begin
          height <= {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
          height <= {1'b0, {(COORD_W-1){1'b1}}};
        end
      end else if (hs > (QB+3)'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
        height <= {1'b0, {(COORD_W-1){1'b1}}};
      end else if (hs < (QB+3)'(signed'({1'b1, {(COORD_W-1){1'b0}}}))) begin
        height <= {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        height <= hs[COORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> src/heightfield_triangle_height_query.sv
// ----------------------------------------------------------------------------
// heightfield_triangle_height_query
// terrain grid store with pipelined triangle plane height lookup
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless the pipeline stalls, vertex
// writes and height queries mixed in any order. Each query yields one
// result; a vertex write yields nothing. The pipeline is one stream: cell
// mapping (a 7-step divide per axis), vertex read from two copies of the
// grid memory (three reads per cycle), normal and numerator (five stages),
// then a 41-step divide of the plane numerator. Writes travel the same
// stages and are applied at the memory read stage, so every query sees
// exactly the writes that came before it. The whole pipeline stalls only
// when a finished result is waiting and the last stage holds another one.
// Vertex memory is not cleared; query only vertices that have been written.
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_triangle_height_query (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  hfq_req_if.sink           req,
  hfq_rsp_if.source         rsp
);
  import hfq_pkg::*;

  localparam int LQ = PLANE_LAT + DIV_LAT;

  typedef struct packed {
    logic                      v;
    logic                      qry;
    logic                      wr_ok;
    logic [AW-1:0]             waddr;
    vertex_t                   wv;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qz;
  } stage_t;

  // configuration registers and derived values
  logic [CNT_W-1:0]  grid_count;
  logic [SIZE_W-1:0] terrain_size;
  logic [SIZE_W-1:0] size_eff;
  logic [CW-1:0]     nm1;
  logic [CW-1:0]     nm2;

  // pipeline
  logic   adv;
  stage_t dl [CELL_LAT+1];
  logic   qv [LQ+1];

  logic [CW-1:0] ix, iz;
  logic [31:0]   rx, rz;
  logic          upper;
  logic [AW-1:0] a1, a2, a3;
  logic          wen;

  vertex_t       va, vb, vc, vc_unused;
  logic signed [COORD_W-1:0] rqx, rqz;

  logic signed [NUM_W-1:0]   num;
  logic signed [NRM_W-1:0]   ny;
  logic signed [COORD_W-1:0] ay;
  logic signed [COORD_W-1:0] h_out;
  logic                      dg_out;

  logic out_v;

  // apb port, always ready
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {1'b0, terrain_size} : {{(32-CNT_W){1'b0}}, grid_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_count   <= CNT_W'(2);
      terrain_size <= SIZE_W'(65536);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        terrain_size <= pwdata[SIZE_W-1:0];
      end else begin
        grid_count <= pwdata[CNT_W-1:0];
      end
    end
  end

  // effective grid count and size
  always_comb begin
    if (grid_count < CNT_W'(2)) begin
      nm1 = CW'(1);
    end else if (int'(grid_count) > GRID_SIDE) begin
      nm1 = CW'(GRID_SIDE - 1);
    end else begin
      nm1 = CW'(grid_count - CNT_W'(1));
    end
    nm2      = nm1 - CW'(1);
    size_eff = (terrain_size == '0) ? SIZE_W'(1) : terrain_size;
  end

  // stall only when the held result is not taken and another is due
  assign adv       = !out_v || rsp.ready || !qv[LQ];
  assign req.ready = adv;

  // request capture and alignment line beside the cell units
  always_ff @(posedge clk) begin
    if (rst) begin
      dl[0].v <= 1'b0;
    end else if (adv) begin
      dl[0].v <= req.valid;
    end
    if (adv) begin
      dl[0].qry   <= req.mode;
      dl[0].wr_ok <= (int'(req.grid_col) < GRID_SIDE) && (int'(req.grid_row) < GRID_SIDE);
      dl[0].waddr <= AW'(int'(req.grid_row) * GRID_SIDE + int'(req.grid_col));
      dl[0].wv    <= '{x: req.vert_x, y: req.vert_y, z: req.vert_z};
      dl[0].qx    <= req.query_x;
      dl[0].qz    <= req.query_z;
    end
  end

  for (genvar i = 1; i <= CELL_LAT; i++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        dl[i].v <= 1'b0;
      end else if (adv) begin
        dl[i].v <= dl[i-1].v;
      end
      if (adv) begin
        dl[i].qry   <= dl[i-1].qry;
        dl[i].wr_ok <= dl[i-1].wr_ok;
        dl[i].waddr <= dl[i-1].waddr;
        dl[i].wv    <= dl[i-1].wv;
        dl[i].qx    <= dl[i-1].qx;
        dl[i].qz    <= dl[i-1].qz;
      end
    end
  end

  hfq_cell u_cell_x (
    .clk      (clk),
    .en       (adv),
    .coord    (dl[0].qx),
    .size     (size_eff),
    .nm1      (nm1),
    .nm2      (nm2),
    .cell_idx (ix),
    .rem      (rx)
  );

  hfq_cell u_cell_z (
    .clk      (clk),
    .en       (adv),
    .coord    (dl[0].qz),
    .size     (size_eff),
    .nm1      (nm1),
    .nm2      (nm2),
    .cell_idx (iz),
    .rem      (rz)
  );

  // triangle pick and vertex addresses
  always_comb begin
    upper = ({1'b0, rx} + {1'b0, rz}) > {1'b0, size_eff, 1'b0};
    if (upper) begin
      a1 = AW'((int'(iz) + 1) * GRID_SIDE + int'(ix) + 1);
    end else begin
      a1 = AW'(int'(iz) * GRID_SIDE + int'(ix));
    end
    a2  = AW'((int'(iz) + 1) * GRID_SIDE + int'(ix));
    a3  = AW'(int'(iz) * GRID_SIDE + int'(ix) + 1);
    wen = adv && dl[CELL_LAT].v && !dl[CELL_LAT].qry && dl[CELL_LAT].wr_ok;
  end

  // two copies of the grid for three reads per cycle while the pipeline advances
  hfq_ram #(.W(VTX_W), .DEPTH(GRID_SIDE * GRID_SIDE)) u_ram_a (
    .clk    (clk),
    .we     (wen),
    .waddr  (dl[CELL_LAT].waddr),
    .wdata  (dl[CELL_LAT].wv),
    .re     (adv),
    .raddr0 (a1),
    .raddr1 (a2),
    .rdata0 (va),
    .rdata1 (vb)
  );

  hfq_ram #(.W(VTX_W), .DEPTH(GRID_SIDE * GRID_SIDE)) u_ram_b (
    .clk    (clk),
    .we     (wen),
    .waddr  (dl[CELL_LAT].waddr),
    .wdata  (dl[CELL_LAT].wv),
    .re     (adv),
    .raddr0 (a3),
    .raddr1 (a3),
    .rdata0 (vc),
    .rdata1 (vc_unused)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      rqx <= dl[CELL_LAT].qx;
      rqz <= dl[CELL_LAT].qz;
    end
  end

  // query valid from the memory output onward
  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (adv) begin
      qv[0] <= dl[CELL_LAT].v && dl[CELL_LAT].qry;
    end
  end

  for (genvar i = 1; i <= LQ; i++) begin : g_qv
    always_ff @(posedge clk) begin
      if (rst) begin
        qv[i] <= 1'b0;
      end else if (adv) begin
        qv[i] <= qv[i-1];
      end
    end
  end

  hfq_plane u_plane (
    .clk (clk),
    .en  (adv),
    .va  (va),
    .vb  (vb),
    .vc  (vc),
    .qx  (rqx),
    .qz  (rqz),
    .num (num),
    .ny  (ny),
    .ay  (ay)
  );

  hfq_div u_div (
    .clk        (clk),
    .en         (adv),
    .num        (num),
    .ny         (ny),
    .ay         (ay),
    .height     (h_out),
    .degenerate (dg_out)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv && qv[LQ]) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
    if (adv && qv[LQ]) begin
      rsp.height     <= h_out;
      rsp.degenerate <= dg_out;
    end
  end

  assign rsp.valid = out_v;

  // a stall means a result is held and not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !adv |-> (out_v && !rsp.ready))
    else $error("pipeline stalled without a blocked result");

  // a finished query always lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (adv && qv[LQ]) |=> out_v)
    else $error("finished query not presented");

  // degenerate heights are saturated or zero
  a_degenerate_value: assert property (@(posedge clk) disable iff (rst)
    (out_v && rsp.degenerate) |->
      (rsp.height == 32'sh0 || rsp.height == 32'sh7FFFFFFF ||
       rsp.height == 32'sh80000000))
    else $error("degenerate height not saturated");

  // a stalled result keeps its payload in the output register
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_v && !rsp.ready) |=> $stable(rsp.height) && $stable(rsp.degenerate))
    else $error("held result changed");

endmodule

`default_nettype wire
